// File: rtl/core/capsule_outline_vertex_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capsule outline vertex generator.
// Each macro states one clocked property under an active-low reset.
// ----------------------------------------------------------------------------
`ifndef CAPSULE_OUTLINE_VERTEX_GENERATOR_ASSERT_SVH
`define CAPSULE_OUTLINE_VERTEX_GENERATOR_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define COVG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define COVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/covg_pkg.sv
// ----------------------------------------------------------------------------
// covg_pkg
// Types and fixed constants shared by the capsule outline vertex generator.
// ----------------------------------------------------------------------------
package covg_pkg;

    localparam int COORD_BITS   = 16;
    localparam int WIDTH_BITS   = 12;
    localparam int INDEX_BITS   = 5;
    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_STEPS = 30;

    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 32'h4000_0000;

    // Inverse CORDIC gain in Q0.30.
    localparam int GAIN_BITS = 30;
    localparam logic [GAIN_BITS-1:0] GAIN_INV_Q30 = 30'd652032874;
    localparam int WK_BITS = WIDTH_BITS + GAIN_BITS;

    // One pixel in Q.4.
    localparam int FRAC_ONE = 16;

    // Normalization brings the larger magnitude into [2^NORM_TOP, 2^(NORM_TOP+1)).
    localparam int NORM_STEPS = 5;
    localparam int NORM_TOP   = 30;
    localparam int M_BITS     = NORM_TOP + 2;

    localparam int VEC_BITS    = 36;
    localparam int ROT_BITS    = 45;
    localparam int ROT_Z_BITS  = ANGLE_BITS + 1;
    localparam int ROUND_SHIFT = 31;
    localparam int RND_BITS    = ROT_BITS - ROUND_SHIFT;
    localparam int SUM_BITS    = COORD_BITS + 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] delta_x;
        logic signed [COORD_BITS-1:0] delta_y;
        logic [WIDTH_BITS-1:0]        line_width;
    } t_seg_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic [INDEX_BITS-1:0]        vertex_index;
        logic                         last_vertex;
    } t_vertex;

    // A classified segment waiting for vertex generation.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] delta_x;
        logic signed [COORD_BITS-1:0] delta_y;
        logic [WK_BITS-1:0]           scaled_width;
        logic [ANGLE_BITS-1:0]        angle;
    } t_seg;

endpackage

// File: rtl/core/capsule_outline_vertex_generator.sv
// ----------------------------------------------------------------------------
// capsule_outline_vertex_generator
// Turns a stroke segment into the outline vertices of a rounded capsule.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                      Word
//  segment  in   accepted when start && !busy   i_seg    (t_seg_in)
//  vertex   out  o_strobe, one cycle, no stall  o_vertex (t_vertex)
//
// The front end works on a segment in five normalization steps, one
// half-turn correction and 30 vectoring CORDIC steps. It takes the next segment
// in the cycle it pushes the current one and not before.
// The back end issues 2*POINTS_PER_CAP vertices, one per cycle, into a 30-stage
// rotation pipeline, followed by a rounding register and an output register.
// Busy is high while the front end works or waits on the full two-entry queue;
// the receiver cannot stall. Reset is synchronous, active low, clears control.
// ----------------------------------------------------------------------------
module capsule_outline_vertex_generator #(
    parameter int POINTS_PER_CAP = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  covg_pkg::t_seg_in i_seg,
    output logic              o_strobe,
    output covg_pkg::t_vertex o_vertex
);
    import covg_pkg::*;

    // Classified segment from the front end into the queue.
    t_seg push_seg;
    logic push;
    logic q_full;

    // Queue head into the back end.
    t_seg pop_seg;
    logic pop;
    logic q_empty;

    // The front end finds the segment direction and the scaled width.
    covg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_seg    (i_seg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_seg    (push_seg)
    );

    // Buffering lets the front end start on a new segment while the back end
    // is still emitting vertices of the previous ones.
    covg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_seg),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_seg),
        .o_empty (q_empty)
    );

    // The back end walks both caps, one vertex word per cycle while it has a segment.
    covg_back #(
        .POINTS_PER_CAP (POINTS_PER_CAP)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_seg    (pop_seg),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_vertex (o_vertex)
    );

endmodule

// File: rtl/core/covg_front.sv
// ----------------------------------------------------------------------------
// covg_front
// Accepts segments, finds the direction angle with a vectoring CORDIC.
// ----------------------------------------------------------------------------
module covg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  covg_pkg::t_seg_in i_seg,
    input  logic              i_q_full,
    output logic              o_push,
    output covg_pkg::t_seg    o_seg
);
    import covg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_FLIP = 3'd2;
    localparam logic [2:0] ST_VEC  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    localparam int CNT_BITS   = $clog2(CORDIC_STEPS);
    localparam int NORM_FIRST = 1 << (NORM_STEPS - 1);
    localparam int NORM_LIMIT = NORM_TOP + 1;
    localparam logic [CNT_BITS-1:0] NORM_LAST = CNT_BITS'(NORM_STEPS - 1);
    localparam logic [CNT_BITS-1:0] VEC_LAST  = CNT_BITS'(CORDIC_STEPS - 1);

    logic [2:0]                  r_state, n_state;
    logic [CNT_BITS-1:0]         r_cnt, n_cnt;
    logic signed [VEC_BITS-1:0]  r_x, n_x, r_y, n_y;
    logic [ANGLE_BITS-1:0]       r_z, n_z;
    logic [M_BITS-1:0]           r_m, n_m;
    logic                        r_zero, n_zero;
    logic signed [COORD_BITS-1:0] r_dx, r_dy;
    logic [WK_BITS-1:0]          r_wk;

    logic                        accept;
    logic signed [COORD_BITS:0]  ext_dx, ext_dy;
    logic [COORD_BITS:0]         abs_dx, abs_dy, abs_max;
    logic [NORM_STEPS-1:0]       norm_sh;
    logic                        norm_go;
    logic signed [VEC_BITS-1:0]  vec_sy, vec_sx;

    assign o_busy = !((r_state == ST_IDLE) || ((r_state == ST_PUSH) && !i_q_full));
    assign o_push = (r_state == ST_PUSH) && !i_q_full;
    assign accept = i_start && !o_busy;

    assign o_seg.delta_x      = r_dx;
    assign o_seg.delta_y      = r_dy;
    assign o_seg.scaled_width = r_wk;
    assign o_seg.angle        = r_zero ? '0 : r_z;

    always_comb begin
        ext_dx  = (COORD_BITS + 1)'(i_seg.delta_x);
        ext_dy  = (COORD_BITS + 1)'(i_seg.delta_y);
        abs_dx  = ext_dx[COORD_BITS] ? -ext_dx : ext_dx;
        abs_dy  = ext_dy[COORD_BITS] ? -ext_dy : ext_dy;
        abs_max = (abs_dx > abs_dy) ? abs_dx : abs_dy;

        norm_sh = NORM_STEPS'(NORM_FIRST >> r_cnt);
        norm_go = (r_m >> (NORM_LIMIT - int'(norm_sh))) == '0;
        vec_sy  = r_y >>> r_cnt;
        vec_sx  = r_x >>> r_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_m     = r_m;
        n_zero  = r_zero;
        unique case (r_state)
            ST_IDLE, ST_PUSH: begin
                if (o_push || (r_state == ST_IDLE)) begin
                    n_state = ST_IDLE;
                end
                if (accept) begin
                    n_state = ST_NORM;
                    n_cnt   = '0;
                    n_x     = VEC_BITS'(i_seg.delta_x);
                    n_y     = VEC_BITS'(i_seg.delta_y);
                    n_z     = '0;
                    n_m     = M_BITS'(abs_max);
                    n_zero  = (abs_max == '0);
                end
            end
            ST_NORM: begin
                if (norm_go) begin
                    n_x = r_x <<< norm_sh;
                    n_y = r_y <<< norm_sh;
                    n_m = r_m << norm_sh;
                end
                if (r_cnt == NORM_LAST) begin
                    n_state = ST_FLIP;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FLIP: begin
                // A vector in the left half plane is turned by a half turn first.
                if (r_x[VEC_BITS-1]) begin
                    n_x = -r_x;
                    n_y = -r_y;
                    n_z = HALF_TURN;
                end
                n_state = ST_VEC;
            end
            ST_VEC: begin
                if (!r_y[VEC_BITS-1]) begin
                    n_x = r_x + vec_sy;
                    n_y = r_y - vec_sx;
                    n_z = r_z + ATAN_TAB[r_cnt];
                end else begin
                    n_x = r_x - vec_sy;
                    n_y = r_y + vec_sx;
                    n_z = r_z - ATAN_TAB[r_cnt];
                end
                if (r_cnt == VEC_LAST) begin
                    n_state = ST_PUSH;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_zero  <= n_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_m <= n_m;
        if (accept) begin
            r_dx <= i_seg.delta_x;
            r_dy <= i_seg.delta_y;
            r_wk <= WK_BITS'(i_seg.line_width) * WK_BITS'(GAIN_INV_Q30);
        end
    end

endmodule

// File: rtl/core/covg_queue.sv
// ----------------------------------------------------------------------------
// covg_queue
// Short first-in first-out buffer of classified segments.
// ----------------------------------------------------------------------------
module covg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  covg_pkg::t_seg i_data,
    output logic           o_full,
    input  logic           i_pop,
    output covg_pkg::t_seg o_data,
    output logic           o_empty
);
    import covg_pkg::*;

    localparam logic [Q_PTR_BITS-1:0] PTR_LAST = Q_PTR_BITS'(Q_DEPTH - 1);
    localparam logic [Q_CNT_BITS-1:0] CNT_FULL = Q_CNT_BITS'(Q_DEPTH);

    t_seg                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wptr, r_rptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/covg_back.sv
// ----------------------------------------------------------------------------
// covg_back
// Issues one vertex per cycle, while it has a segment, into a pipelined rotation CORDIC.
// ----------------------------------------------------------------------------
module covg_back #(
    parameter int POINTS_PER_CAP = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  covg_pkg::t_seg    i_seg,
    output logic              o_pop,
    output logic              o_strobe,
    output covg_pkg::t_vertex o_vertex
);
    import covg_pkg::*;

    localparam int TOTAL = 2 * POINTS_PER_CAP;
    localparam int JW    = $clog2(POINTS_PER_CAP);
    localparam int VW    = $clog2(TOTAL);
    localparam int VXW   = (VW > INDEX_BITS) ? VW : INDEX_BITS;
    localparam logic [JW-1:0] J_LAST = JW'(POINTS_PER_CAP - 1);

    localparam logic signed [ROT_BITS-1:0] ROUND_HALF = ROT_BITS'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        {{(SUM_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] bx;
        logic signed [SUM_BITS-1:0] by;
        logic [INDEX_BITS-1:0]      idx;
        logic                       last;
    } t_side;

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[COORD_BITS-1:0];
    endfunction

    // Offset angle of each cap vertex, from -90 degrees in equal steps.
    logic [ANGLE_BITS-1:0] phi_tab [POINTS_PER_CAP];
    for (genvar g = 0; g < POINTS_PER_CAP; g++) begin : g_phi
        localparam logic [63:0] PHI_RAW =
            (64'(g) * 64'h8000_0000 + 64'((POINTS_PER_CAP - 1) / 2)) / (POINTS_PER_CAP - 1);
        assign phi_tab[g] = PHI_RAW[ANGLE_BITS-1:0] - QUARTER_TURN;
    end

    // Issue sequencer and the segment being worked on.
    logic                       r_active, n_active;
    logic [JW-1:0]              r_j, n_j;
    logic                       r_half, n_half;
    logic [VW-1:0]              r_v, n_v;
    logic [ANGLE_BITS-1:0]      r_theta;
    logic signed [ROT_BITS-1:0] r_wkp, r_wkn;
    logic signed [SUM_BITS-1:0] r_bx1, r_by1;

    logic                       last_issue;
    logic [ANGLE_BITS-1:0]      iss_angle;
    logic signed [ANGLE_BITS-1:0] iss_z;
    logic                       iss_flip;
    logic [VXW-1:0]             v_ext;
    logic signed [ROT_BITS-1:0] ld_wk;

    assign last_issue = r_active && r_half && (r_j == J_LAST);
    assign o_pop      = !i_empty && (!r_active || last_issue);
    assign ld_wk      = $signed({{(ROT_BITS - WK_BITS){1'b0}}, i_seg.scaled_width});

    always_comb begin
        n_active = r_active;
        n_j      = r_j;
        n_half   = r_half;
        n_v      = r_v;
        if (o_pop) begin
            n_active = 1'b1;
            n_j      = '0;
            n_half   = 1'b0;
            n_v      = '0;
        end else if (last_issue) begin
            n_active = 1'b0;
        end else if (r_active) begin
            n_v = r_v + 1'b1;
            if (r_j == J_LAST) begin
                n_j    = '0;
                n_half = 1'b1;
            end else begin
                n_j = r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_j      <= '0;
            r_half   <= 1'b0;
            r_v      <= '0;
        end else begin
            r_active <= n_active;
            r_j      <= n_j;
            r_half   <= n_half;
            r_v      <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_theta <= i_seg.angle;
            r_wkp   <= ld_wk;
            r_wkn   <= -ld_wk;
            r_bx1   <= SUM_BITS'(i_seg.delta_x) + SUM_BITS'(FRAC_ONE);
            r_by1   <= SUM_BITS'(i_seg.delta_y);
        end
    end

    // Rotation pipeline, stage 0 is the issue register.
    logic signed [ROT_BITS-1:0]   r_px [CORDIC_STEPS+1];
    logic signed [ROT_BITS-1:0]   r_py [CORDIC_STEPS+1];
    logic signed [ROT_Z_BITS-1:0] r_pz [CORDIC_STEPS+1];
    t_side                        r_ps [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]        r_pv;

    always_comb begin
        iss_angle = r_theta + phi_tab[r_j] + (r_half ? HALF_TURN : '0);
        iss_z     = $signed(iss_angle);
        iss_flip  = (iss_z > $signed(QUARTER_TURN)) || (iss_z < -$signed(QUARTER_TURN));
        v_ext     = VXW'(r_v);
    end

    always_ff @(posedge i_clk) begin
        r_px[0] <= iss_flip ? r_wkn : r_wkp;
        r_py[0] <= '0;
        // Flipping bit 31 moves the angle by a half turn into [-90, 90] degrees.
        r_pz[0] <= iss_flip ? ROT_Z_BITS'($signed(iss_angle ^ HALF_TURN)) : ROT_Z_BITS'(iss_z);
        r_ps[0].bx   <= r_half ? SUM_BITS'(FRAC_ONE) : r_bx1;
        r_ps[0].by   <= r_half ? '0 : r_by1;
        r_ps[0].idx  <= v_ext[INDEX_BITS-1:0];
        r_ps[0].last <= r_half && (r_j == J_LAST);
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        localparam logic signed [ROT_Z_BITS-1:0] ATAN_K = $signed({1'b0, ATAN_TAB[k]});
        always_ff @(posedge i_clk) begin
            if (!r_pz[k][ROT_Z_BITS-1]) begin
                r_px[k+1] <= r_px[k] - (r_py[k] >>> k);
                r_py[k+1] <= r_py[k] + (r_px[k] >>> k);
                r_pz[k+1] <= r_pz[k] - ATAN_K;
            end else begin
                r_px[k+1] <= r_px[k] + (r_py[k] >>> k);
                r_py[k+1] <= r_py[k] - (r_px[k] >>> k);
                r_pz[k+1] <= r_pz[k] + ATAN_K;
            end
            r_ps[k+1] <= r_ps[k];
        end
    end

    // Rounding to Q.4 halves the width, then the offset is added and clamped.
    logic signed [ROT_BITS-1:0] rnd_x, rnd_y;
    logic signed [RND_BITS-1:0] r_rx, r_ry;
    t_side                      r_rs;
    logic                       r_rv;
    logic signed [SUM_BITS-1:0] sum_x, sum_y;
    t_vertex                    r_vertex;
    logic                       r_strobe;

    assign rnd_x = r_px[CORDIC_STEPS] + ROUND_HALF;
    assign rnd_y = r_py[CORDIC_STEPS] + ROUND_HALF;
    assign sum_x = r_rs.bx + SUM_BITS'(r_rx);
    assign sum_y = r_rs.by + SUM_BITS'(r_ry);

    always_ff @(posedge i_clk) begin
        r_rx <= rnd_x[ROT_BITS-1:ROUND_SHIFT];
        r_ry <= rnd_y[ROT_BITS-1:ROUND_SHIFT];
        r_rs <= r_ps[CORDIC_STEPS];
        r_vertex.vertex_x     <= sat(sum_x);
        r_vertex.vertex_y     <= sat(sum_y);
        r_vertex.vertex_index <= r_rs.idx;
        r_vertex.last_vertex  <= r_rs.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= '0;
            r_rv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pv     <= {r_pv[CORDIC_STEPS-1:0], r_active};
            r_rv     <= r_pv[CORDIC_STEPS];
            r_strobe <= r_rv;
        end
    end

    assign o_strobe = r_strobe;
    assign o_vertex = r_vertex;

endmodule

// File: rtl/core/covg_checker.sv
// ----------------------------------------------------------------------------
// covg_checker
// Port-level checks on busy and the vertex stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "capsule_outline_vertex_generator_assert.svh"

module covg_checker #(
    parameter int POINTS_PER_CAP = 15
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input covg_pkg::t_vertex o_vertex
);
    import covg_pkg::*;

    localparam logic [INDEX_BITS-1:0] LAST_IDX = INDEX_BITS'(2 * POINTS_PER_CAP - 1);

    // Taking a segment occupies the front end, so busy is high after it.
    `COVG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "busy did not rise after a segment was taken")

    // The last vertex carries the final outline position.
    `COVG_ASSERT_IMPLIES(a_last_index, i_clk, i_rst_n, o_strobe && o_vertex.last_vertex, o_vertex.vertex_index == LAST_IDX, "last vertex flagged at the wrong position")

    // Vertices of one outline come on consecutive cycles in order.
    `COVG_ASSERT_NEXT(a_burst_step, i_clk, i_rst_n, o_strobe && !o_vertex.last_vertex, o_strobe && (o_vertex.vertex_index == INDEX_BITS'($past(o_vertex.vertex_index) + 1'b1)), "gap or misordered vertex inside an outline")

    // An outline that starts after a gap starts at its first vertex.
    `COVG_ASSERT_IMPLIES(a_burst_start, i_clk, i_rst_n, o_strobe && !$past(o_strobe), o_vertex.vertex_index == '0, "outline did not start at vertex zero")

endmodule

bind capsule_outline_vertex_generator covg_checker #(
    .POINTS_PER_CAP (POINTS_PER_CAP)
) u_covg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_vertex (o_vertex)
);

// File: sim/capsule_outline_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_outline_checker
// Watches the segment and vertex channels of the capsule outline vertex
// generator, predicts the outline of every accepted segment and compares
// each vertex word field by field.
// ----------------------------------------------------------------------------
module capsule_outline_checker
    import covg_pkg::*;
#(
    parameter int POINTS_PER_CAP = 15
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_seg_in i_seg,
    input  logic    i_strobe,
    input  t_vertex i_vertex,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);

    localparam int     OUTLINE_LEN = 2 * POINTS_PER_CAP;
    localparam int     ITERS       = 30;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint ONE_HALF_Q31 = 64'sd1 <<< 30;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

    // Binary-angle arctangent table, one turn = 2^32.
    localparam logic [31:0] ARCTAN [ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    t_vertex expected_vertices[$];
    int      fails;
    int      checked;

    // Direction of the segment as a binary angle, by vectoring.
    function automatic logic [31:0] heading_angle(longint dx, longint dy);
        longint      x;
        longint      y;
        longint      nx;
        longint      mag;
        logic [31:0] z;
        int          k;
        if (dx == 0 && dy == 0) begin
            return 32'd0;
        end
        x   = (dx < 0) ? -dx : dx;
        y   = (dy < 0) ? -dy : dy;
        mag = (x > y) ? x : y;
        k   = 0;
        while (mag < (64'sd1 <<< 30) && k < 62) begin
            mag = mag * 2;
            k++;
        end
        x = dx * (64'sd1 <<< k);
        y = dy * (64'sd1 <<< k);
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = TURN_HALF;
        end
        for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN[i];
            end
            x = nx;
        end
        return z;
    endfunction

    // Half-width offset at the given angle, by rotation of (width * K, 0).
    function automatic void half_width_offset(input logic [31:0] angle, input longint w,
                                              output longint ox, output longint oy);
        longint x;
        longint y;
        longint nx;
        longint z;
        x = w * GAIN_Q30;
        y = 0;
        z = longint'({32'd0, angle});
        if (angle >= TURN_HALF) begin
            z = z - (64'sd1 <<< 32);
        end
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
            x = -x;
            z = (z > 0) ? z - (64'sd1 <<< 31) : z + (64'sd1 <<< 31);
        end
        for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'({32'd0, ARCTAN[i]});
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'({32'd0, ARCTAN[i]});
            end
            x = nx;
        end
        ox = (x + ONE_HALF_Q31) >>> 31;
        oy = (y + ONE_HALF_Q31) >>> 31;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        return COORD_BITS'(v);
    endfunction

    // Appends the whole outline of one segment to the expected vertices.
    function automatic void predict_outline(t_seg_in seg);
        longint      dx;
        longint      dy;
        longint      w;
        longint      cx;
        longint      cy;
        longint      ox;
        longint      oy;
        logic [31:0] theta;
        logic [31:0] phi;
        int          j;
        t_vertex     v;
        dx    = longint'($signed(seg.delta_x));
        dy    = longint'($signed(seg.delta_y));
        w     = longint'({52'd0, seg.line_width});
        theta = heading_angle(dx, dy);
        for (int i = 0; i < OUTLINE_LEN; i++) begin
            j   = (i < POINTS_PER_CAP) ? i : i - POINTS_PER_CAP;
            phi = 32'((longint'(j) * (64'sd1 <<< 31) + longint'((POINTS_PER_CAP - 1) / 2))
                      / longint'(POINTS_PER_CAP - 1)) - TURN_QUARTER;
            phi = phi + theta;
            if (i < POINTS_PER_CAP) begin
                cx = dx + FRAC_ONE;
                cy = dy;
            end else begin
                cx  = FRAC_ONE;
                cy  = 0;
                phi = phi + TURN_HALF;
            end
            half_width_offset(phi, w, ox, oy);
            v.vertex_x     = clamp_coord(cx + ox);
            v.vertex_y     = clamp_coord(cy + oy);
            v.vertex_index = INDEX_BITS'(i);
            v.last_vertex  = (i == OUTLINE_LEN - 1);
            expected_vertices.push_back(v);
        end
    endfunction

    initial begin
        fails        = 0;
        checked      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_vertices.size() == 0) begin
                    $error("vertex word with none expected: x %0d y %0d index %0d",
                           i_vertex.vertex_x, i_vertex.vertex_y, i_vertex.vertex_index);
                    fails++;
                end else begin
                    want = expected_vertices.pop_front();
                    checked++;
                    if (i_vertex.vertex_x !== want.vertex_x) begin
                        $error("vertex_x: expected %0d, got %0d",
                               want.vertex_x, i_vertex.vertex_x);
                        fails++;
                    end
                    if (i_vertex.vertex_y !== want.vertex_y) begin
                        $error("vertex_y: expected %0d, got %0d",
                               want.vertex_y, i_vertex.vertex_y);
                        fails++;
                    end
                    if (i_vertex.vertex_index !== want.vertex_index) begin
                        $error("vertex_index: expected %0d, got %0d",
                               want.vertex_index, i_vertex.vertex_index);
                        fails++;
                    end
                    if (i_vertex.last_vertex !== want.last_vertex) begin
                        $error("last_vertex: expected %0d, got %0d",
                               want.last_vertex, i_vertex.last_vertex);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_outline(i_seg);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_vertices.size();
        o_checked    <= checked;
    end

endmodule

// File: sim/capsule_outline_vertex_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capsule_outline_vertex_generator_test
// Drives stroke segments into the capsule outline vertex generator and lets
// the checker compare every outline vertex against its own prediction.
// ----------------------------------------------------------------------------
module capsule_outline_vertex_generator_test;
    import covg_pkg::*;

    localparam int POINTS_PER_CAP = 15;
    localparam int RANDOM_WORDS   = 330;
    // Longest correct quiet spell is a sender gap plus the pipeline latency;
    // this limit leaves a wide margin over it.
    localparam int QUIET_LIMIT    = 3000;
    // Drain time after the last expected vertex, beyond the pipeline latency.
    localparam int TAIL_CYCLES    = 150;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_seg_in i_seg;
    logic    o_strobe;
    t_vertex o_vertex;

    int fail_count;
    int pending_vertices;
    int checked_vertices;
    int idle_pct;
    int directed_sent;
    int random_sent;
    int quiet_cycles;

    capsule_outline_vertex_generator #(
        .POINTS_PER_CAP(POINTS_PER_CAP)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_seg   (i_seg),
        .o_strobe(o_strobe),
        .o_vertex(o_vertex)
    );

    // The checker sees exactly what the block sees and keeps the verdict count.
    capsule_outline_checker #(
        .POINTS_PER_CAP(POINTS_PER_CAP)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_seg       (i_seg),
        .i_strobe    (o_strobe),
        .i_vertex    (o_vertex),
        .o_fail_count(fail_count),
        .o_pending   (pending_vertices),
        .o_checked   (checked_vertices)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: any cycle in which neither a segment nor a vertex word moves
    // counts toward the limit. A hung block therefore ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one segment word and returns at the edge that accepts it. Before
    // the offer the sender may go idle for a random number of cycles; during
    // such a gap the word lines carry noise, which the block must ignore since
    // start is low. The gaps can outlast the front end's turn on a segment, so
    // they land on every phase of it.
    task automatic send_segment(input int dx, input int dy, input int w);
        t_seg_in word;
        t_seg_in noise;
        int      gap;
        word.delta_x    = COORD_BITS'(dx);
        word.delta_y    = COORD_BITS'(dy);
        word.line_width = WIDTH_BITS'(w);
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 60);
            start <= 1'b0;
            repeat (gap) begin
                noise.delta_x    = COORD_BITS'($urandom);
                noise.delta_y    = COORD_BITS'($urandom);
                noise.line_width = WIDTH_BITS'($urandom);
                i_seg <= noise;
                @(posedge i_clk);
            end
        end
        // Start stays high across back-to-back words, so it is only ever
        // raised here and never lowered in the same step.
        start <= 1'b1;
        i_seg <= word;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    initial begin
        int sel;
        int dx;
        int dy;
        int w;

        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_seg            = '0;
        quiet_cycles     = 0;
        idle_pct         = 31;
        directed_sent    = 0;
        random_sent      = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed segments. A zero-length segment takes the angle as zero;
        // zero width collapses each half onto its centre point; the largest
        // deltas and widths push vertices past the coordinate range so the
        // outputs saturate; a negative delta_x exercises the half-turn
        // correction before vectoring.
        send_segment(0, 0, 0);
        send_segment(0, 0, 4095);
        send_segment(16, 0, 32);
        send_segment(-16, 0, 32);
        send_segment(0, 16, 32);
        send_segment(0, -16, 32);
        send_segment(-1, -1, 1);
        send_segment(32767, 32767, 4095);
        send_segment(-32768, -32768, 4095);
        send_segment(-32768, 0, 4095);
        send_segment(0, -32768, 4095);
        send_segment(32767, -32768, 100);
        send_segment(-32768, 32767, 100);
        send_segment(32767, 0, 0);
        send_segment(-17, 0, 0);
        send_segment(1, 1, 4095);
        send_segment(-32768, 1, 2000);
        send_segment(-32768, -1, 2000);
        send_segment(5, -3, 4094);
        send_segment(0, 1, 1);
        send_segment(-32768, 32767, 4095);
        directed_sent = 21;

        // Random segments. Most are short strokes with moderate widths, as a
        // drawing would produce; the rest span the full field ranges, sit on
        // the axes and diagonals where the vectoring ends near a quadrant
        // boundary, or hug the coordinate extremes.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // A long stretch with the sender never idle keeps the block
            // saturated so back-to-back acceptance is exercised.
            idle_pct = (n >= 120 && n < 200) ? 0 : 31;
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                dx = int'($urandom_range(0, 4095)) - 2048;
                dy = int'($urandom_range(0, 4095)) - 2048;
                w  = $urandom_range(0, 512);
            end else if (sel < 80) begin
                dx = int'($urandom_range(0, 65535)) - 32768;
                dy = int'($urandom_range(0, 65535)) - 32768;
                w  = $urandom_range(0, 4095);
            end else if (sel < 92) begin
                dx = int'($urandom_range(0, 65535)) - 32768;
                w  = $urandom_range(0, 4095);
                case ($urandom_range(0, 3))
                    0: begin
                        dy = 0;
                    end
                    1: begin
                        dy = dx;
                        dx = 0;
                    end
                    2: begin
                        dy = dx;
                    end
                    default: begin
                        dy = (dx == -32768) ? 32767 : -dx;
                    end
                endcase
            end else begin
                dx = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                          : -32768 + int'($urandom_range(0, 3));
                dy = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                          : -32768 + int'($urandom_range(0, 3));
                w  = 4095 - int'($urandom_range(0, 7));
            end
            send_segment(dx, dy, w);
            random_sent++;
        end

        start <= 1'b0;

        // Wait for every predicted vertex, then a little longer so a stray
        // extra word would still be caught. The watchdog bounds this wait.
        while (pending_vertices != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d directed and %0d random segments, sender gaps on and off.",
                 directed_sent, random_sent);
        $display("Compared %0d outline vertices, including saturated and zero-width cases.",
                 checked_vertices);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/covg_pkg.sv
rtl/core/covg_front.sv
rtl/core/covg_queue.sv
rtl/core/covg_back.sv
rtl/core/capsule_outline_vertex_generator.sv
rtl/core/covg_checker.sv
sim/capsule_outline_checker.sv
sim/capsule_outline_vertex_generator_test.sv
